FILE: rtl/bucketed_hash_table_unit_assert.svh
// Assertion macros shared by the bucketed hash table checker.
`ifndef BUCKETED_HASH_TABLE_UNIT_ASSERT_SVH
`define BUCKETED_HASH_TABLE_UNIT_ASSERT_SVH

// Overlapping implication, sampled on clk_i, off during reset.
`define BHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bht_pkg.sv
// Shared types and constants of the bucketed hash table unit.
package bht_pkg;

  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;
  localparam int ENT_W       = KEY_W + VAL_W;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  // Bucket index: key bits folded into the remainder, per cycle.
  localparam int HASH_BITS  = 8;
  localparam int HASH_STEPS = (KEY_W + HASH_BITS - 1) / HASH_BITS;
  localparam int KEY_PAD_W  = HASH_STEPS * HASH_BITS;
  localparam int STEP_W     = $clog2(HASH_STEPS);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_CMP   = 5'b10000
  } state_e;

endpackage

FILE: rtl/bucketed_hash_table_unit.sv
// Bucketed key-value table: insert, search and delete over fixed-depth buckets.
//
// Each transfer on the slave side is one operation; each gives one result transfer.
// The bucket is key modulo NUM_BUCKETS and holds up to WAYS entries, newest first,
// all kept with the bucket's fill count in one row of a single RAM. An operation
// reduces the key to a bucket index (eight key bits a cycle), reads the RAM row,
// compares all slots and writes the shifted row back, then returns to idle to take
// the next transfer. The compare waits while an earlier result is still held
// unaccepted. The result waits in an output register, so the next operation is
// accepted while it is still pending. After reset a clearing pass zeroes each of
// the NUM_BUCKETS rows, and so the fill counts, before the first transfer is taken.
module bucketed_hash_table_unit #(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [bht_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // key[30:0], value[62:31]
  input  logic [bht_pkg::OP_W-1:0]           s_axis_tuser_i,   // operation[1:0]
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [bht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,   // found_value[31:0]
  output logic [bht_pkg::ST_W-1:0]           m_axis_tuser_o    // status[1:0]
);

  localparam int BKT_W = $clog2(NUM_BUCKETS);
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam int SLT_W = WAYS * bht_pkg::ENT_W;
  localparam int ROW_W = SLT_W + CNT_W;
  localparam logic [BKT_W:0]   NbC      = (BKT_W + 1)'(NUM_BUCKETS);
  localparam logic [BKT_W-1:0] LastBkt  = BKT_W'(NUM_BUCKETS - 1);
  localparam logic [CNT_W-1:0] WaysC    = CNT_W'(WAYS);
  localparam logic [bht_pkg::STEP_W-1:0] LastStep = bht_pkg::STEP_W'(bht_pkg::HASH_STEPS - 1);

  bht_pkg::state_e state_q, state_d;
  bht_pkg::op_e    op_q;
  logic [bht_pkg::KEY_W-1:0]     key_q;
  logic [bht_pkg::VAL_W-1:0]     val_q;
  logic [bht_pkg::KEY_PAD_W-1:0] key_sh_q, key_sh_d;
  logic [BKT_W-1:0]              rem_q, rem_d, rem_next;
  logic [bht_pkg::STEP_W-1:0]    step_q, step_d;
  logic [BKT_W-1:0]              clr_q, clr_d;
  logic                          out_valid_q, out_valid_d;
  logic [bht_pkg::ST_W-1:0]      out_status_q, out_status_d;
  logic [bht_pkg::VAL_W-1:0]     out_value_q, out_value_d;

  logic             in_xfer, out_free, cmp_go;
  logic             ram_we, ram_re;
  logic [BKT_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, rd_row;

  logic [CNT_W-1:0]          fill_raw, fill;
  logic [bht_pkg::ENT_W-1:0] slot [WAYS];
  logic [bht_pkg::VAL_W-1:0] hit_val [WAYS];
  logic [WAYS-1:0]           hit, first_hit, at_or_after;
  logic [SLT_W-1:0]          ins_row, del_row;
  logic [bht_pkg::VAL_W-1:0] found_val;
  logic                      row_we;
  logic [ROW_W-1:0]          row_wdata;
  logic [bht_pkg::ST_W-1:0]  cmp_status;
  logic [bht_pkg::VAL_W-1:0] cmp_value;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cmp_go   = (state_q == bht_pkg::S_CMP) && out_free;

  // key modulo NUM_BUCKETS, HASH_BITS key bits per cycle, MSB first
  always_comb begin : hash_step
    logic [BKT_W:0]   t;
    logic [BKT_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < bht_pkg::HASH_BITS; j++) begin
      t = {r, key_sh_q[bht_pkg::KEY_PAD_W-1-j]};
      if (t >= NbC) begin
        t = t - NbC;
      end
      r = t[BKT_W-1:0];
    end
    rem_next = r;
  end

  // bucket row compare and shift
  assign fill_raw = rd_row[SLT_W +: CNT_W];
  assign fill     = (fill_raw > WaysC) ? WaysC : fill_raw;

  for (genvar g = 0; g < WAYS; g++) begin : g_slot
    assign slot[g]    = rd_row[g*bht_pkg::ENT_W +: bht_pkg::ENT_W];
    assign hit[g]     = (CNT_W'(g) < fill) && (slot[g][bht_pkg::KEY_W-1:0] == key_q);
    assign hit_val[g] = first_hit[g] ? slot[g][bht_pkg::ENT_W-1:bht_pkg::KEY_W] : '0;
    if (g == 0) begin : g_head
      assign ins_row[g*bht_pkg::ENT_W +: bht_pkg::ENT_W] = {val_q, key_q};
    end else begin : g_body
      assign ins_row[g*bht_pkg::ENT_W +: bht_pkg::ENT_W] = slot[g-1];
    end
    if (g == WAYS - 1) begin : g_tail
      assign del_row[g*bht_pkg::ENT_W +: bht_pkg::ENT_W] = slot[g];
    end else begin : g_mid
      assign del_row[g*bht_pkg::ENT_W +: bht_pkg::ENT_W] =
        at_or_after[g] ? slot[g+1] : slot[g];
    end
  end

  assign first_hit   = hit & (~hit + WAYS'(1));
  assign at_or_after = ~(first_hit - WAYS'(1));

  always_comb begin
    found_val = '0;
    for (int i = 0; i < WAYS; i++) begin
      found_val = found_val | hit_val[i];
    end
  end

  always_comb begin
    row_we     = 1'b0;
    row_wdata  = {fill + CNT_W'(1), ins_row};
    cmp_status = bht_pkg::ST_MISS;
    cmp_value  = '0;
    unique case (op_q)
      bht_pkg::OP_INSERT: begin
        if (fill >= WaysC) begin
          cmp_status = bht_pkg::ST_FULL;
        end else begin
          row_we     = 1'b1;
          cmp_status = bht_pkg::ST_OK;
        end
      end
      bht_pkg::OP_SEARCH: begin
        if (|hit) begin
          cmp_status = bht_pkg::ST_OK;
          cmp_value  = found_val;
        end
      end
      bht_pkg::OP_DELETE: begin
        row_wdata = {fill - CNT_W'(1), del_row};
        if (|hit) begin
          row_we     = 1'b1;
          cmp_status = bht_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  // control
  always_comb begin
    state_d      = state_q;
    key_sh_d     = key_sh_q;
    rem_d        = rem_q;
    step_d       = step_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    ram_we       = 1'b0;
    ram_waddr    = rem_q;
    ram_wdata    = row_wdata;
    ram_re       = 1'b0;
    unique case (state_q)
      bht_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + BKT_W'(1);
        if (clr_q == LastBkt) begin
          state_d = bht_pkg::S_IDLE;
        end
      end
      bht_pkg::S_IDLE: begin
        if (in_xfer) begin
          key_sh_d = bht_pkg::KEY_PAD_W'(s_axis_tdata_i[bht_pkg::KEY_W-1:0]);
          rem_d    = '0;
          step_d   = '0;
          state_d  = bht_pkg::S_HASH;
        end
      end
      bht_pkg::S_HASH: begin
        rem_d    = rem_next;
        key_sh_d = key_sh_q << bht_pkg::HASH_BITS;
        step_d   = step_q + bht_pkg::STEP_W'(1);
        if (step_q == LastStep) begin
          state_d = bht_pkg::S_READ;
        end
      end
      bht_pkg::S_READ: begin
        ram_re  = 1'b1;
        state_d = bht_pkg::S_CMP;
      end
      bht_pkg::S_CMP: begin
        if (cmp_go) begin
          ram_we       = row_we;
          out_valid_d  = 1'b1;
          out_status_d = cmp_status;
          out_value_d  = cmp_value;
          state_d      = bht_pkg::S_IDLE;
        end
      end
      default: state_d = bht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bht_pkg::S_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= bht_pkg::op_e'(s_axis_tuser_i);
      key_q <= s_axis_tdata_i[bht_pkg::KEY_W-1:0];
      val_q <= s_axis_tdata_i[bht_pkg::ENT_W-1:bht_pkg::KEY_W];
    end
    key_sh_q     <= key_sh_d;
    rem_q        <= rem_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  bht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rem_q),
    .rdata_o (rd_row)
  );

  assign s_axis_tready_o = (state_q == bht_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule

FILE: rtl/bht_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bht_checker.sv
// Port-level checker for the bucketed hash table unit, bound to the top level.
`include "bucketed_hash_table_unit_assert.svh"

module bht_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [bht_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [bht_pkg::OP_W-1:0]        s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [bht_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [bht_pkg::ST_W-1:0]        m_axis_tuser_o
);

  `BHT_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

  `BHT_ASSERT_NOW(a_value_zero, m_axis_tvalid_o && (m_axis_tuser_o != bht_pkg::ST_OK), m_axis_tdata_o == '0, "nonzero value on failed operation")

  `BHT_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input taken while operation in flight")

  `BHT_ASSERT_NOW(a_result_after_work, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o), "result without operation in flight")

endmodule

bind bucketed_hash_table_unit bht_checker u_bht_checker (.*);

FILE: dv/bucketed_hash_table_unit_checker.sv
`timescale 1ns / 100ps
// Checker for the bucketed hash table unit: it models the table from observed operations and scores each result.
module bucketed_hash_table_unit_checker
  import bht_pkg::*;
#(
  parameter int NUM_BUCKETS = 16,
  parameter int WAYS        = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // key[30:0], value[62:31]
  input  logic [OP_W-1:0]        s_axis_tuser_i,   // operation[1:0]
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_i,   // found_value[31:0]
  input  logic [ST_W-1:0]        m_axis_tuser_i,   // status[1:0]
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     ok_count_o,
  output int                     miss_count_o,
  output int                     full_count_o
);

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] found_value;
  } answer_t;

  logic [KEY_W-1:0] slot_key [NUM_BUCKETS][WAYS];
  logic [VAL_W-1:0] slot_val [NUM_BUCKETS][WAYS];
  int               bucket_fill [NUM_BUCKETS];
  answer_t          expected_answers [$];

  // Applies one operation to the table copy and returns the answer it gives.
  task automatic apply_table_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value, output answer_t ans);
    int b;
    int n;
    int hit;
    b = key % NUM_BUCKETS;
    n = bucket_fill[b];
    hit = -1;
    ans.status = ST_MISS;
    ans.found_value = '0;
    if (op == OP_SEARCH || op == OP_DELETE) begin
      for (int i = n - 1; i >= 0; i--) begin
        if (slot_key[b][i] == key) hit = i;
      end
    end
    case (op)
      OP_INSERT: begin
        if (n >= WAYS) begin
          ans.status = ST_FULL;
        end else begin
          for (int i = n; i > 0; i--) begin
            slot_key[b][i] = slot_key[b][i-1];
            slot_val[b][i] = slot_val[b][i-1];
          end
          slot_key[b][0] = key;
          slot_val[b][0] = value;
          bucket_fill[b] = n + 1;
          ans.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          ans.status = ST_OK;
          ans.found_value = slot_val[b][hit];
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          for (int i = hit; i + 1 < n; i++) begin
            slot_key[b][i] = slot_key[b][i+1];
            slot_val[b][i] = slot_val[b][i+1];
          end
          bucket_fill[b] = n - 1;
          ans.status = ST_OK;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    answer_t ans;
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUCKETS; b++) bucket_fill[b] = 0;
      expected_answers.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_answers.size() == 0) begin
          $error("result transfer with no operation outstanding");
          fail_count_o++;
        end else begin
          want = expected_answers.pop_front();
          if (m_axis_tuser_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser_i);
            fail_count_o++;
          end
          if (m_axis_tdata_i !== want.found_value) begin
            $error("found_value: expected %0h, got %0h", want.found_value, m_axis_tdata_i);
            fail_count_o++;
          end
          case (want.status)
            ST_OK:   ok_count_o++;
            ST_MISS: miss_count_o++;
            default: full_count_o++;
          endcase
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_table_op(s_axis_tuser_i, s_axis_tdata_i[KEY_W-1:0],
                       s_axis_tdata_i[KEY_W+VAL_W-1:KEY_W], ans);
        expected_answers.push_back(ans);
      end
      pending_o = expected_answers.size();
    end
  end

endmodule

FILE: dv/bucketed_hash_table_unit_test.sv
`timescale 1ns / 100ps
// Testbench top for the bucketed hash table unit: clock, reset, stimulus, stalls and verdict.
module bucketed_hash_table_unit_test;
  import bht_pkg::*;

  localparam int NUM_BUCKETS    = 16;
  localparam int WAYS           = 4;
  localparam int PHASES         = 6;
  localparam int PHASE_OPS      = 238;
  localparam int POOL_KEYS      = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX   = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_valid;
  logic [IN_TDATA_W-1:0]  s_data;
  logic [OP_W-1:0]        s_user;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic                   m_ready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [ST_W-1:0]        m_axis_tuser_o;

  int fail_count;
  int pending;
  int ok_count;
  int miss_count;
  int full_count;

  logic             idle_on;
  int               stall_left;
  int               idle_cycles;
  int               ops_sent;
  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  bucketed_hash_table_unit #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS       (WAYS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  bucketed_hash_table_unit_checker #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS       (WAYS)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_axis_tdata_o),
    .m_axis_tuser_i (m_axis_tuser_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .ok_count_o     (ok_count),
    .miss_count_o   (miss_count),
    .full_count_o   (full_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones; none while idling is off.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_ready <= 1'b1;
    end else if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= pick_gap();
      m_ready <= ($urandom_range(0, 99) < 60);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, value, key};
    s_user  <= op;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    ops_sent++;
  endtask

  task automatic wait_for_results();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic fill_key_pool();
    int buckets [3];
    logic [KEY_W-1:0] k;
    foreach (buckets[i]) buckets[i] = $urandom_range(0, NUM_BUCKETS - 1);
    foreach (key_pool[i]) begin
      k = $urandom;
      key_pool[i] = k - (k % NUM_BUCKETS) + buckets[$urandom_range(0, 2)];
    end
  endtask

  initial begin
    int r;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    s_valid    = 1'b0;
    s_data     = '0;
    s_user     = OP_INSERT;
    m_ready    = 1'b0;
    idle_on    = 1'b1;
    stall_left = 0;
    rst_ni     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extremes, duplicates, full bucket, misses, unused code
    send_op(OP_SEARCH, 31'd5, 32'd0);
    send_op(OP_DELETE, 31'd5, 32'd0);
    send_op(OP_INSERT, 31'd0, VAL_MIN);
    send_op(OP_INSERT, KEY_MAX, VAL_MAX);
    send_op(OP_SEARCH, 31'd0, 32'd0);
    send_op(OP_SEARCH, KEY_MAX, 32'd0);
    send_op(OP_INSERT, 31'd16, 32'd1);
    send_op(OP_INSERT, 31'd0, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 31'd32, 32'd2);
    send_op(OP_INSERT, 31'd48, 32'h5555_5555);
    send_op(OP_SEARCH, 31'd0, 32'd0);
    send_op(OP_DELETE, 31'd0, 32'd0);
    send_op(OP_SEARCH, 31'd0, 32'd0);
    send_op(OP_SEARCH, 31'd48, 32'd0);
    send_op(OP_UNUSED, 31'd0, 32'hAAAA_AAAA);
    send_op(OP_DELETE, 31'd16, 32'd0);
    send_op(OP_SEARCH, 31'd32, 32'd0);
    send_op(OP_SEARCH, 31'd16, 32'd0);
    send_op(OP_DELETE, 31'd0, 32'd0);
    send_op(OP_DELETE, 31'd32, 32'd0);
    send_op(OP_SEARCH, 31'd0, 32'd0);
    send_op(OP_INSERT, 31'h7FFF_FFF0, 32'hAAAA_AAAA);
    send_op(OP_SEARCH, 31'd0, 32'd0);
    send_op(OP_SEARCH, 31'h7FFF_FFF0, 32'd0);
    wait_for_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on <= (phase != 2);
      fill_key_pool();
      for (int n = 0; n < PHASE_OPS; n++) begin
        r   = $urandom_range(0, 99);
        key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        if (r < 36) begin
          op = OP_INSERT;
        end else if (r < 68) begin
          op = OP_SEARCH;
        end else if (r < 92) begin
          op = OP_DELETE;
        end else begin
          op  = $urandom_range(0, 3);
          key = $urandom;
        end
        send_op(op, key, $urandom);
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d table operations in %0d random phases after a directed set.",
             ops_sent, PHASES);
    $display("Results seen: %0d done or found, %0d not found, %0d bucket full.",
             ok_count, miss_count, full_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
